@@ design/cprs_pkg.sv @@
package cprs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned LEVEL_W    = 5;
  localparam int unsigned GEN_LIM_W  = 4;
  localparam int unsigned ESC_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [GEN_LIM_W-1:0] GEN_LIMIT_RST  = GEN_LIM_W'(1);
  localparam logic [ESC_W-1:0]     ESC_COUNT_RST  = ESC_W'(8);
  localparam logic [ESC_W-1:0]     ESC_SAT_MAX    = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_COUNT     = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ_TAIL = 2'd0,
    OP_ENQ_HEAD = 2'd1,
    OP_SELECT   = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef struct packed {
    logic            interactive;
    logic            kind;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic start;
    logic step_scan;
    logic step_move;
    logic pick;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_select;
    logic in_shift;
    logic walk_done;
    logic pick_any;
    logic out_free;
  } status_t;

endpackage

@@ design/cprs_req_if.sv @@
interface cprs_req_if import cprs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic            kind;
  logic            interactive;
  logic [ID_W-1:0] id;

  modport source (output valid, op, kind, interactive, id, input ready);
  modport sink (input valid, op, kind, interactive, id, output ready);
endinterface

@@ design/cprs_rsp_if.sv @@
interface cprs_rsp_if import cprs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [ID_W-1:0]    granted_id;
  logic               granted_kind;
  logic               granted_interactive;
  logic               accepted;
  logic [LEVEL_W-1:0] queue_level;
  logic [GEN_LIM_W-1:0] active_generations;

  modport source (
    output valid, granted, granted_id, granted_kind, granted_interactive, accepted,
           queue_level, active_generations,
    input  ready
  );
  modport sink (
    input  valid, granted, granted_id, granted_kind, granted_interactive, accepted,
           queue_level, active_generations,
    output ready
  );
endinterface

@@ design/cprs_ctrl.sv @@
module cprs_ctrl import cprs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_PICK   = 5'b00100,
    ST_MOVE   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          if (status_i.in_select) begin
            state_d = ST_SCAN;
          end else if (status_i.in_shift) begin
            state_d = ST_MOVE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.step_scan = 1'b1;
        if (status_i.walk_done) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = status_i.pick_any ? ST_MOVE : ST_FINISH;
      end
      ST_MOVE: begin
        cmd_o.step_move = 1'b1;
        if (status_i.walk_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/cprs_datapath.sv @@
module cprs_datapath import cprs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       req_op_i,
  input  logic                  req_kind_i,
  input  logic                  req_interactive_i,
  input  logic [ID_W-1:0]       req_id_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic                  rsp_granted_o,
  output logic [ID_W-1:0]       rsp_granted_id_o,
  output logic                  rsp_granted_kind_o,
  output logic                  rsp_granted_interactive_o,
  output logic                  rsp_accepted_o,
  output logic [LEVEL_W-1:0]    rsp_queue_level_o,
  output logic [GEN_LIM_W-1:0]  rsp_active_generations_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t mem_q [QUEUE_DEPTH];

  logic [GEN_LIM_W-1:0] glim_q;
  logic [ESC_W-1:0]     esc_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ESC_W-1:0]     gsr_q, gsr_d;
  logic [GEN_LIM_W-1:0] act_q, act_d;

  op_e             op_q;
  logic            kind_q;
  entry_t          item_q;

  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             dir_up_q, dir_up_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_pos_q, rd_pos_d;
  entry_t           rd_data_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic             has_gen_q, has_rem_q, has_irem_q;
  logic [IDX_W-1:0] p_gen_q, p_rem_q, p_irem_q;
  entry_t           e_gen_q, e_rem_q, e_irem_q;

  logic             pick_q;
  entry_t           res_entry_q;

  logic             sel_irem, sel_rem, sel_gen, pick_any;
  logic [IDX_W-1:0] sel_pos;
  entry_t           sel_entry;

  logic             full;
  logic             enq_ok;

  logic                 out_valid_q;
  logic                 out_granted_q;
  entry_t               out_entry_q;
  logic                 out_accepted_q;
  logic [LEVEL_W-1:0]   out_level_q;
  logic [GEN_LIM_W-1:0] out_act_q;

  assign full = (count_q == DEPTH_CNT);

  always_comb begin
    sel_irem = has_irem_q && (!has_gen_q || (gsr_q < esc_q));
    sel_rem  = !sel_irem && has_rem_q && (!has_gen_q || (gsr_q >= esc_q));
    sel_gen  = !sel_irem && !sel_rem && has_gen_q && (act_q < glim_q);
    pick_any = sel_irem || sel_rem || sel_gen;
    priority if (sel_irem) begin
      sel_pos   = p_irem_q;
      sel_entry = e_irem_q;
    end else if (sel_rem) begin
      sel_pos   = p_rem_q;
      sel_entry = e_rem_q;
    end else if (sel_gen) begin
      sel_pos   = p_gen_q;
      sel_entry = e_gen_q;
    end else begin
      sel_pos   = '0;
      sel_entry = '0;
    end
  end

  always_comb begin
    status_o.in_select = (op_e'(req_op_i) == OP_SELECT);
    status_o.in_shift  = (op_e'(req_op_i) == OP_ENQ_HEAD) && (count_q != '0) && !full;
    status_o.walk_done = (dir_up_q ? (ptr_q == '0) : (ptr_q >= count_q)) && !rd_vld_q;
    status_o.pick_any  = pick_any;
    status_o.out_free  = !out_valid_q || rsp_ready_i;
  end

  // The same read pipeline walks forward for a scan or a gap close and
  // backward to open the head slot.
  always_comb begin
    ptr_d    = ptr_q;
    dir_up_d = dir_up_q;
    rd_vld_d = 1'b0;
    rd_pos_d = rd_pos_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    if (cmd_i.start) begin
      if (op_e'(req_op_i) == OP_ENQ_HEAD) begin
        ptr_d    = count_q;
        dir_up_d = 1'b1;
      end else begin
        ptr_d    = '0;
        dir_up_d = 1'b0;
      end
    end else if (cmd_i.pick) begin
      ptr_d    = CNT_W'(sel_pos) + CNT_W'(1);
      dir_up_d = 1'b0;
    end else if (cmd_i.step_scan || cmd_i.step_move) begin
      if (dir_up_q) begin
        if (ptr_q != '0) begin
          rd_en    = 1'b1;
          rd_addr  = IDX_W'(ptr_q - CNT_W'(1));
          rd_pos_d = rd_addr;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q - CNT_W'(1);
        end
      end else if (ptr_q < count_q) begin
        rd_en    = 1'b1;
        rd_addr  = IDX_W'(ptr_q);
        rd_pos_d = rd_addr;
        rd_vld_d = 1'b1;
        ptr_d    = ptr_q + CNT_W'(1);
      end
    end
  end

  assign enq_ok = ((op_q == OP_ENQ_TAIL) || (op_q == OP_ENQ_HEAD)) && !full;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_q;
    if (cmd_i.step_move && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = dir_up_q ? (rd_pos_q + IDX_W'(1)) : (rd_pos_q - IDX_W'(1));
    end else if (cmd_i.commit && enq_ok) begin
      wr_en   = 1'b1;
      wr_addr = (op_q == OP_ENQ_HEAD) ? '0 : IDX_W'(count_q);
      wr_data = item_q;
    end
  end

  always_comb begin
    count_d = count_q;
    gsr_d   = gsr_q;
    act_d   = act_q;
    if (cmd_i.pick) begin
      if (sel_irem || sel_rem) begin
        gsr_d = '0;
      end else if (sel_gen) begin
        if (gsr_q != ESC_SAT_MAX) begin
          gsr_d = gsr_q + ESC_W'(1);
        end
        act_d = act_q + GEN_LIM_W'(1);
      end
    end else if (cmd_i.commit) begin
      if (enq_ok) begin
        count_d = count_q + CNT_W'(1);
      end else if ((op_q == OP_SELECT) && pick_q) begin
        count_d = count_q - CNT_W'(1);
      end else if ((op_q == OP_COMPLETE) && !kind_q && (act_q != '0)) begin
        act_d = act_q - GEN_LIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glim_q   <= GEN_LIMIT_RST;
      esc_q    <= ESC_COUNT_RST;
      count_q  <= '0;
      gsr_q    <= '0;
      act_q    <= '0;
      ptr_q    <= '0;
      dir_up_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_GENERATION_LIMIT: glim_q <= cfg_data_i[GEN_LIM_W-1:0];
          CFG_ESCAPE_COUNT:     esc_q  <= cfg_data_i[ESC_W-1:0];
          default: ;
        endcase
      end
      count_q  <= count_d;
      gsr_q    <= gsr_d;
      act_q    <= act_d;
      ptr_q    <= ptr_d;
      dir_up_q <= dir_up_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    if (cmd_i.start) begin
      op_q               <= op_e'(req_op_i);
      kind_q             <= req_kind_i;
      item_q.id          <= req_id_i;
      item_q.kind        <= req_kind_i;
      item_q.interactive <= req_interactive_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_gen_q  <= 1'b0;
      has_rem_q  <= 1'b0;
      has_irem_q <= 1'b0;
      pick_q     <= 1'b0;
    end else if (cmd_i.start) begin
      has_gen_q  <= 1'b0;
      has_rem_q  <= 1'b0;
      has_irem_q <= 1'b0;
      pick_q     <= 1'b0;
    end else if (cmd_i.pick) begin
      pick_q <= pick_any;
    end else if (cmd_i.step_scan && rd_vld_q) begin
      if (rd_data_q.kind) begin
        if (!has_rem_q) begin
          has_rem_q <= 1'b1;
        end
        if (rd_data_q.interactive && !has_irem_q) begin
          has_irem_q <= 1'b1;
        end
      end else if (!has_gen_q) begin
        has_gen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_entry_q <= '0;
    end else if (cmd_i.pick) begin
      res_entry_q <= sel_entry;
    end
    if (cmd_i.step_scan && rd_vld_q) begin
      if (rd_data_q.kind) begin
        if (!has_rem_q) begin
          p_rem_q <= rd_pos_q;
          e_rem_q <= rd_data_q;
        end
        if (rd_data_q.interactive && !has_irem_q) begin
          p_irem_q <= rd_pos_q;
          e_irem_q <= rd_data_q;
        end
      end else if (!has_gen_q) begin
        p_gen_q <= rd_pos_q;
        e_gen_q <= rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_granted_q  <= pick_q;
      out_entry_q    <= res_entry_q;
      out_accepted_q <= enq_ok;
      out_level_q    <= LEVEL_W'(count_d);
      out_act_q      <= act_d;
    end
  end

  assign rsp_valid_o               = out_valid_q;
  assign rsp_granted_o             = out_granted_q;
  assign rsp_granted_id_o          = out_entry_q.id;
  assign rsp_granted_kind_o        = out_entry_q.kind;
  assign rsp_granted_interactive_o = out_entry_q.interactive;
  assign rsp_accepted_o            = out_accepted_q;
  assign rsp_queue_level_o         = out_level_q;
  assign rsp_active_generations_o  = out_act_q;

endmodule

@@ design/class_priority_request_scheduler_core.sv @@
// Class-aware request scheduler over a queue memory of QUEUE_DEPTH entries
// with one read port and one write port. Every word on the request channel
// gives exactly one word on the response channel, and a new request word is
// taken once the previous one has been handed to the response register, even
// while that response still waits. A tail enqueue, a complete, or a head
// enqueue on an empty or full queue does not walk the queue memory; any other
// head enqueue walks it once to open the head slot. A select walks it once to
// find the first entry of each class and, when it grants an entry, once more
// to close the gap behind the grant. The queue memory is walked one entry per
// cycle. Each request waits to finish while an earlier response still holds
// the response register. Configuration writes take effect at once and must be
// issued only while no request is in flight.
module class_priority_request_scheduler_core import cprs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cprs_req_if.sink              req_i,
  cprs_rsp_if.source            rsp_o
);

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  cprs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cprs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cfg_we_i                  (cfg_we_i),
    .cfg_index_i               (cfg_index_i),
    .cfg_data_i                (cfg_data_i),
    .req_op_i                  (req_i.op),
    .req_kind_i                (req_i.kind),
    .req_interactive_i         (req_i.interactive),
    .req_id_i                  (req_i.id),
    .cmd_i                     (cmd),
    .status_o                  (status),
    .rsp_ready_i               (rsp_o.ready),
    .rsp_valid_o               (rsp_o.valid),
    .rsp_granted_o             (rsp_o.granted),
    .rsp_granted_id_o          (rsp_o.granted_id),
    .rsp_granted_kind_o        (rsp_o.granted_kind),
    .rsp_granted_interactive_o (rsp_o.granted_interactive),
    .rsp_accepted_o            (rsp_o.accepted),
    .rsp_queue_level_o         (rsp_o.queue_level),
    .rsp_active_generations_o  (rsp_o.active_generations)
  );

  assign req_i.ready = req_ready;

endmodule

@@ verif/tb_class_priority_request_scheduler_core.sv @@
module tb_class_priority_request_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cprs_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned SETTING_STEPS   = 7;
  localparam int unsigned WORDS_PER_STEP  = 250;
  localparam int unsigned PRESSURE_WORDS  = 40;

  localparam logic [GEN_LIM_W-1:0] LIMIT_STEPS [SETTING_STEPS] =
    '{4'd1, 4'd15, 4'd0, 4'd3, 4'd15, 4'd2, 4'd8};
  localparam logic [ESC_W-1:0] ESCAPE_STEPS [SETTING_STEPS] =
    '{8'd8, 8'd255, 8'd1, 8'd0, 8'd1, 8'd3, 8'd128};

  typedef struct packed {
    logic                 granted;
    logic [ID_W-1:0]      id;
    logic                 kind;
    logic                 interactive;
    logic                 accepted;
    logic [LEVEL_W-1:0]   level;
    logic [GEN_LIM_W-1:0] active;
  } grant_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cprs_req_if req_if ();
  cprs_rsp_if rsp_if ();

  class_priority_request_scheduler_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  entry_t               waiting_q [$];
  logic [ESC_W-1:0]     since_remesh = '0;
  logic [GEN_LIM_W-1:0] active_gens  = '0;
  logic [GEN_LIM_W-1:0] gen_limit    = GEN_LIMIT_RST;
  logic [ESC_W-1:0]     escape_cnt   = ESC_COUNT_RST;

  grant_report_t pending_reports [$];

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 61;
  int unsigned hold_asks     = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned settings_done = 0;
  int unsigned gen_grants    = 0;
  int unsigned remesh_grants = 0;
  int unsigned empty_selects = 0;
  int unsigned refused_words = 0;

  function automatic grant_report_t schedule_step(input op_e op, input logic kind,
                                                  input logic mark,
                                                  input logic [ID_W-1:0] id);
    grant_report_t r;
    entry_t        e;
    int            p_gen  = -1;
    int            p_rem  = -1;
    int            p_irem = -1;
    int            pick   = -1;
    r = '0;
    e.id = id;
    e.kind = kind;
    e.interactive = mark;
    case (op)
      OP_ENQ_TAIL, OP_ENQ_HEAD: begin
        if (waiting_q.size() < QUEUE_DEPTH_DEF) begin
          if (op == OP_ENQ_TAIL) waiting_q.insert(waiting_q.size(), e);
          else waiting_q.insert(0, e);
          r.accepted = 1'b1;
        end else begin
          refused_words++;
        end
      end
      OP_SELECT: begin
        foreach (waiting_q[i]) begin
          if (waiting_q[i].kind) begin
            if (p_rem < 0) p_rem = i;
            if (waiting_q[i].interactive && p_irem < 0) p_irem = i;
          end else if (p_gen < 0) begin
            p_gen = i;
          end
        end
        if (p_irem >= 0 && (p_gen < 0 || since_remesh < escape_cnt)) begin
          pick = p_irem;
          since_remesh = '0;
        end else if (p_rem >= 0 && (p_gen < 0 || since_remesh >= escape_cnt)) begin
          pick = p_rem;
          since_remesh = '0;
        end else if (p_gen >= 0 && active_gens < gen_limit) begin
          pick = p_gen;
          if (since_remesh != ESC_SAT_MAX) since_remesh++;
          active_gens++;
        end
        if (pick >= 0) begin
          r.granted = 1'b1;
          r.id = waiting_q[pick].id;
          r.kind = waiting_q[pick].kind;
          r.interactive = waiting_q[pick].interactive;
          waiting_q.delete(pick);
          if (r.kind) remesh_grants++;
          else gen_grants++;
        end else begin
          empty_selects++;
        end
      end
      default: begin
        if (!kind && active_gens != '0) active_gens--;
      end
    endcase
    r.level = LEVEL_W'(waiting_q.size());
    r.active = active_gens;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  task automatic check_report();
    grant_report_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      $display("%0t: response word with nothing outstanding, expected none, actual 0x%0h",
               $time, rsp_if.granted_id);
    end else begin
      want = pending_reports[0];
      pending_reports.delete(0);
      check_field("granted", 32'(want.granted), 32'(rsp_if.granted));
      check_field("granted_id", 32'(want.id), 32'(rsp_if.granted_id));
      check_field("granted_kind", 32'(want.kind), 32'(rsp_if.granted_kind));
      check_field("granted_interactive", 32'(want.interactive),
                  32'(rsp_if.granted_interactive));
      check_field("accepted", 32'(want.accepted), 32'(rsp_if.accepted));
      check_field("queue_level", 32'(want.level), 32'(rsp_if.queue_level));
      check_field("active_generations", 32'(want.active), 32'(rsp_if.active_generations));
    end
  endtask

  task automatic send_word(input op_e op, input logic kind, input logic mark,
                           input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.kind <= kind;
    req_if.interactive <= mark;
    req_if.id <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_reports.insert(pending_reports.size(), schedule_step(op, kind, mark, id));
    words_sent++;
  endtask

  task automatic send_random_word(input int unsigned mode);
    int unsigned     roll;
    int unsigned     enq_pct;
    int unsigned     sel_pct;
    op_e             op;
    logic            kind;
    logic            mark;
    logic [ID_W-1:0] id;
    enq_pct = (mode == 0) ? 65 : (mode == 1) ? 40 : 20;
    sel_pct = enq_pct + ((mode == 2) ? 50 : 35);
    roll = $urandom_range(99);
    if (roll < enq_pct) op = ($urandom_range(2) == 0) ? OP_ENQ_HEAD : OP_ENQ_TAIL;
    else if (roll < sel_pct) op = OP_SELECT;
    else op = OP_COMPLETE;
    kind = 1'($urandom);
    mark = 1'($urandom);
    case ($urandom_range(15))
      0: id = '0;
      1: id = '1;
      default: id = ID_W'($urandom);
    endcase
    if (op == OP_COMPLETE) kind = ($urandom_range(99) < 85) ? 1'b0 : 1'b1;
    send_word(op, kind, mark, id);
  endtask

  task automatic drain_reports();
    req_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_reports.size() != 0);
  endtask

  task automatic set_config(input logic [GEN_LIM_W-1:0] limit,
                            input logic [ESC_W-1:0] escape);
    drain_reports();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_GENERATION_LIMIT;
    cfg_data_i <= {4'($urandom), limit};
    @(posedge clk_i);
    cfg_index_i <= CFG_ESCAPE_COUNT;
    cfg_data_i <= escape;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_limit = limit;
    escape_cnt = escape;
    settings_done++;
  endtask

  task automatic test_idle_queue();
    send_word(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_word(OP_COMPLETE, 1'b0, 1'b0, 16'h0000);
    send_word(OP_COMPLETE, 1'b1, 1'b1, 16'hFFFF);
  endtask

  // A marked generation never counts as interactive, and a saturated
  // generation limit leaves a select with nothing eligible.
  task automatic test_class_order();
    send_word(OP_ENQ_TAIL, 1'b0, 1'b1, 16'h0000);
    send_word(OP_ENQ_TAIL, 1'b1, 1'b0, 16'hFFFF);
    send_word(OP_ENQ_HEAD, 1'b1, 1'b1, 16'hA5A5);
    send_word(OP_ENQ_TAIL, 1'b0, 1'b0, 16'h5A5A);
    send_word(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_word(OP_SELECT, 1'b1, 1'b1, 16'hFFFF);
    send_word(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_word(OP_COMPLETE, 1'b1, 1'b0, 16'h0000);
    send_word(OP_COMPLETE, 1'b0, 1'b1, 16'hFFFF);
    send_word(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_word(OP_SELECT, 1'b0, 1'b0, 16'h0000);
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < QUEUE_DEPTH_DEF + 2; i++) begin
      send_word(i[0] ? OP_ENQ_HEAD : OP_ENQ_TAIL, 1'($urandom), 1'($urandom),
                ID_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned total;
    int unsigned k;
    int unsigned mode;
    total = SETTING_STEPS * WORDS_PER_STEP;
    mode = 0;
    for (int s = 0; s < SETTING_STEPS; s++) begin
      set_config(LIMIT_STEPS[s], ESCAPE_STEPS[s]);
      for (int n = 0; n < WORDS_PER_STEP; n++) begin
        k = s * WORDS_PER_STEP + n;
        case (k * 3 / total)
          0: begin
            send_idle_pct = 12;
            recv_idle_pct <= 61;
          end
          1: begin
            send_idle_pct = 61;
            recv_idle_pct <= 12;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
          end
        endcase
        if (k % 40 == 0) mode = $urandom_range(2);
        send_random_word(mode);
      end
    end
  endtask

  task automatic test_pressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < PRESSURE_WORDS; i++) send_random_word(1);
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_report();
      if (hold_asks != hold_served) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles without a handshake", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_GENERATION_LIMIT;
    cfg_data_i <= '0;
    req_if.valid <= 1'b0;
    req_if.op <= OP_ENQ_TAIL;
    req_if.kind <= 1'b0;
    req_if.interactive <= 1'b0;
    req_if.id <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_queue();
    test_class_order();
    test_queue_full();
    test_random_traffic();
    test_pressure();

    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d request words over %0d register settings, with a long response stall.",
             words_sent, settings_done);
    $display("Saw %0d generation grants, %0d remesh grants, %0d empty selects, %0d refusals.",
             gen_grants, remesh_grants, empty_selects, refused_words);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
